/* hw/rtl/bpt_pkg.sv */
// Package for the beep pattern timer: command and phase codes, payload structs.
// No dependencies; used by bpt_core and beep_pattern_timer_unit.
`default_nettype none

package bpt_pkg;

   localparam int TIME_WIDTH_DEFAULT = 16;
   localparam int FIELD_WIDTH        = 16;

   typedef enum logic [1:0] {
      CMD_TICK  = 2'd0,
      CMD_START = 2'd1,
      CMD_STOP  = 2'd2
   } cmd_type;

   typedef enum logic [1:0] {
      PH_IDLE = 2'd0,
      PH_ON   = 2'd1,
      PH_OFF  = 2'd2
   } phase_type;

   typedef struct packed {
      logic [1:0]                    cmd;
      logic [FIELD_WIDTH-1:0]        on_time;
      logic [FIELD_WIDTH-1:0]        off_time;
      logic signed [FIELD_WIDTH-1:0] repeat_count;
   } req_type;

   typedef struct packed {
      logic buzzer_level;
      logic active;
   } rsp_type;

endpackage

`default_nettype wire

/* hw/rtl/bpt_core.sv */
// Pattern state (phase, elapsed, lengths, repeats) and its next-state logic.
// Depends on bpt_pkg.
`default_nettype none

module bpt_core #(
   parameter int TIME_WIDTH = bpt_pkg::TIME_WIDTH_DEFAULT
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             advance,
   input  wire bpt_pkg::req_type item,
   output bpt_pkg::rsp_type      result
);

   localparam int FW = bpt_pkg::FIELD_WIDTH;

   bpt_pkg::phase_type      phase_ff, phase_in;
   logic [TIME_WIDTH-1:0]   elapsed_ff, elapsed_in;
   logic [TIME_WIDTH-1:0]   on_len_ff, on_len_in;
   logic [TIME_WIDTH-1:0]   off_len_ff, off_len_in;
   logic signed [FW-1:0]    cycles_ff, cycles_in;

   logic [TIME_WIDTH-1:0]   elapsed_inc;
   logic [TIME_WIDTH-1:0]   on_clamped;
   logic [TIME_WIDTH-1:0]   off_clamped;
   logic                    counting;
   logic                    last_cycle;

   // start lengths saturate when the time counter is narrower than the field
   if (TIME_WIDTH >= FW) begin : g_wide
      assign on_clamped  = TIME_WIDTH'(item.on_time);
      assign off_clamped = TIME_WIDTH'(item.off_time);
   end else begin : g_narrow
      assign on_clamped  = (|item.on_time[FW-1:TIME_WIDTH]) ? '1
                                                             : item.on_time[TIME_WIDTH-1:0];
      assign off_clamped = (|item.off_time[FW-1:TIME_WIDTH]) ? '1
                                                              : item.off_time[TIME_WIDTH-1:0];
   end

   assign elapsed_inc = (&elapsed_ff) ? elapsed_ff : elapsed_ff + TIME_WIDTH'(1);
   assign counting    = (cycles_ff > FW'(0));
   assign last_cycle  = (cycles_ff == FW'(1));

   always_comb begin
      phase_in   = phase_ff;
      elapsed_in = elapsed_ff;
      on_len_in  = on_len_ff;
      off_len_in = off_len_ff;
      cycles_in  = cycles_ff;
      unique case (item.cmd)
         bpt_pkg::CMD_TICK: begin
            unique case (phase_ff)
               bpt_pkg::PH_ON: begin
                  if (elapsed_inc < on_len_ff) begin
                     elapsed_in = elapsed_inc;
                  end else begin
                     elapsed_in = '0;
                     if (off_len_ff == '0) begin
                        // zero gap: count the cycle and stay on unless it was the last
                        if (counting) begin
                           cycles_in = cycles_ff - FW'(1);
                        end
                        if (last_cycle) begin
                           phase_in = bpt_pkg::PH_IDLE;
                        end
                     end else begin
                        phase_in = bpt_pkg::PH_OFF;
                     end
                  end
               end
               bpt_pkg::PH_OFF: begin
                  if (elapsed_inc < off_len_ff) begin
                     elapsed_in = elapsed_inc;
                  end else begin
                     elapsed_in = '0;
                     if (counting) begin
                        cycles_in = cycles_ff - FW'(1);
                     end
                     phase_in = last_cycle ? bpt_pkg::PH_IDLE : bpt_pkg::PH_ON;
                  end
               end
               default: begin
               end
            endcase
         end
         bpt_pkg::CMD_START: begin
            on_len_in  = on_clamped;
            off_len_in = off_clamped;
            cycles_in  = item.repeat_count;
            phase_in   = bpt_pkg::PH_ON;
            elapsed_in = '0;
         end
         bpt_pkg::CMD_STOP: begin
            phase_in  = bpt_pkg::PH_IDLE;
            cycles_in = '0;
         end
         default: begin
         end
      endcase
   end

   assign result.buzzer_level = (phase_in == bpt_pkg::PH_ON);
   assign result.active       = (phase_in == bpt_pkg::PH_ON) || (phase_in == bpt_pkg::PH_OFF);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= bpt_pkg::PH_IDLE;
         elapsed_ff <= '0;
         on_len_ff  <= '0;
         off_len_ff <= '0;
         cycles_ff  <= '0;
      end else if (advance) begin
         phase_ff   <= phase_in;
         elapsed_ff <= elapsed_in;
         on_len_ff  <= on_len_in;
         off_len_ff <= off_len_in;
         cycles_ff  <= cycles_in;
      end
   end

endmodule

`default_nettype wire

/* hw/rtl/beep_pattern_timer_unit.sv */
// Beep pattern timer: input register, pattern core, result register.
// A request is held in the input register, passes the core, and its result is held in the result register.
// Takes one request per cycle while req_stall is low; the core updates once per request.
// Synchronous active-high reset clears the pattern to idle and empties both registers.
// Depends on bpt_pkg and bpt_core.
`default_nettype none

module beep_pattern_timer_unit #(
   parameter int TIME_WIDTH = bpt_pkg::TIME_WIDTH_DEFAULT
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output      logic             req_stall,
   input  wire bpt_pkg::req_type req_data,
   output      logic             rsp_valid,
   input  wire logic             rsp_stall,
   output      bpt_pkg::rsp_type rsp_data
);

   logic             in_valid_ff;
   bpt_pkg::req_type in_data_ff;
   logic             out_valid_ff;
   bpt_pkg::rsp_type out_data_ff;
   bpt_pkg::rsp_type core_result;
   logic             advance;
   logic             req_xfer;

   // the input stage moves on when the result register is free or being drained
   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && out_valid_ff && rsp_stall;
   assign req_xfer  = req_valid && !req_stall;

   bpt_core #(
      .TIME_WIDTH(TIME_WIDTH)
   ) u_core (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .item    (in_data_ff),
      .result  (core_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_xfer) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         in_data_ff <= req_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_data_ff <= core_result;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

endmodule

`default_nettype wire
